[hw/rtl/pid_sat_pkg.sv]
package pid_sat_pkg;

  // Field and register widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned DtW     = 16;
  localparam int unsigned FracW   = 16;
  localparam int unsigned IntegW  = 48;
  localparam int unsigned CfgIdxW = 3;

  // Shared multiplier: parallel multiplicand, radix-4 serial multiplier
  localparam int unsigned McandW  = IntegW;
  localparam int unsigned MplierW = DataW;
  localparam int unsigned ProdW   = McandW + 2 + MplierW - FracW;

  // Serial divider: |error difference| << FracW over the time step
  localparam int unsigned DivMagW = DataW + 1;
  localparam int unsigned QuoW    = DivMagW + DtW;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[hw/rtl/pid_sat_mul.sv]
module pid_sat_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [pid_sat_pkg::McandW-1:0]  mcand,
  input  logic signed [pid_sat_pkg::MplierW-1:0] mplier,
  output logic signed [pid_sat_pkg::ProdW-1:0]   prod,
  output pid_sat_pkg::unit_stat_t                stat
);
  import pid_sat_pkg::*;

  localparam int unsigned AccW  = McandW + 2;
  localparam int unsigned Steps = MplierW / 2;
  localparam int unsigned CntW  = $clog2(Steps);

  logic signed [McandW-1:0] v_r;
  logic [MplierW:0]         g_r;
  logic signed [AccW-1:0]   a_r;
  logic [MplierW-1:0]       drop_r;
  logic [CntW-1:0]          cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic signed [AccW-1:0]   v_ext;
  logic signed [AccW-1:0]   pp;
  logic signed [AccW-1:0]   s;

  assign v_ext = {{(AccW-McandW){v_r[McandW-1]}}, v_r};

  // Booth radix-4 digit select
  always_comb begin
    case (g_r[2:0])
      3'b001, 3'b010: pp = v_ext;
      3'b011:         pp = v_ext <<< 1;
      3'b100:         pp = -(v_ext <<< 1);
      3'b101, 3'b110: pp = -v_ext;
      default:        pp = '0;
    endcase
  end

  assign s = a_r + pp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= mcand;
        g_r    <= {mplier, 1'b0};
        a_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // advance one digit, shift the low bits out into drop_r
        a_r    <= s >>> 2;
        drop_r <= {s[1:0], drop_r[MplierW-1:2]};
        g_r    <= {2'b00, g_r[MplierW:2]};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CntW'(Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // floor(mcand * mplier / 2^FracW)
  assign prod      = $signed({a_r, drop_r[MplierW-1:FracW]});
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hw/rtl/pid_sat_div.sv]
module pid_sat_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [pid_sat_pkg::DivMagW-1:0]      mag,
  input  logic [pid_sat_pkg::DtW-1:0]          divisor,
  output logic [pid_sat_pkg::QuoW-1:0]         quo,
  output pid_sat_pkg::unit_stat_t              stat
);
  import pid_sat_pkg::*;

  localparam int unsigned CntW = $clog2(QuoW);

  logic [DtW-1:0]  d_r;
  logic [DtW-1:0]  rem_r;
  logic [QuoW-1:0] quo_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DtW:0]    t;
  logic [DtW:0]    t_sub;
  logic            ge;

  assign t     = {rem_r, quo_r[QuoW-1]};
  assign ge    = (t >= {1'b0, d_r});
  assign t_sub = t - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        d_r    <= divisor;
        rem_r  <= '0;
        quo_r  <= {mag, {FracW{1'b0}}};
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // restoring step: one quotient bit per cycle
        rem_r <= ge ? t_sub[DtW-1:0] : t[DtW-1:0];
        quo_r <= {quo_r[QuoW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(QuoW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hw/rtl/pid_controller_saturated_unit.sv]
// PID controller with output clamp, signed Q16.16, digit-serial datapath.
// One item at a time: in_stall stays high until its result is registered, and
// a finished result waits while out_stall holds a previous one. Four 16-step
// radix-4 multiplies run on the one shared multiplier (the 49-step divider
// overlaps the first three). Reset (rst_n low, synchronous): integral,
// previous error and gains clear, limits span the full range, no result pending.
module pid_controller_saturated_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pid_sat_pkg::DataW-1:0]   in_target,
  input  logic signed [pid_sat_pkg::DataW-1:0]   in_measured,
  input  logic [pid_sat_pkg::DtW-1:0]            in_step_time,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pid_sat_pkg::DataW-1:0]   out_drive,
  output logic                                   out_clamped,
  // configuration
  input  logic                                   cfg_we,
  input  logic [pid_sat_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pid_sat_pkg::DataW-1:0]          cfg_wdata
);
  import pid_sat_pkg::*;

  localparam logic [CfgIdxW-1:0] RegGainP  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOutMin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutMax = 3'd4;

  localparam logic [DataW-1:0]  DataMax  = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0]  DataMin  = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
  localparam logic [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,      // wait for an item
    ST_PREP,      // form error difference, launch divider and error*dt
    ST_MUL_I,     // error*dt for the integral
    ST_MUL_P,     // gain_p*error
    ST_MUL_K,     // gain_i*integral
    ST_DIV_WAIT,  // hold until the derivative quotient is ready
    ST_MUL_D,     // gain_d*derivative
    ST_CLAMP      // limit the sum and hand it to the output register
  } state_t;

  state_t state_r;

  // configuration registers
  logic signed [DataW-1:0] gain_p_r;
  logic signed [DataW-1:0] gain_i_r;
  logic signed [DataW-1:0] gain_d_r;
  logic signed [DataW-1:0] out_min_r;
  logic signed [DataW-1:0] out_max_r;

  // controller state
  logic signed [IntegW-1:0] integral_r;
  logic signed [DataW-1:0]  last_error_r;

  // per-item working registers
  logic signed [DataW-1:0]   err_r;
  logic [DtW-1:0]            dt_r;
  logic                      diff_neg_r;
  logic signed [ProdW-1:0]   sum_r;
  logic signed [McandW-1:0]  mcand_r;
  logic signed [MplierW-1:0] mplier_r;
  logic                      mul_start_r;

  // output register
  logic                    out_valid_r;
  logic signed [DataW-1:0] out_drive_r;
  logic                    out_clamped_r;

  // unit links
  logic signed [ProdW-1:0] mul_prod;
  unit_stat_t              mul_stat;
  logic [QuoW-1:0]         div_quo;
  unit_stat_t              div_stat;
  logic                    div_start;

  // datapath
  logic [DataW:0]           err_wide;
  logic [DataW-1:0]         err_sat;
  logic [DataW:0]           diff_wide;
  logic [DivMagW-1:0]       diff_mag;
  logic [DataW-1:0]         deriv;
  logic [IntegW:0]          integ_sum;
  logic [IntegW-1:0]        integ_sat;
  logic signed [ProdW-1:0]  sum_add;
  logic signed [ProdW-1:0]  hi_ext;
  logic signed [ProdW-1:0]  lo_ext;
  logic                     over;
  logic                     under;
  logic                     out_free;

  // error = target - measured, saturated to 32 bits
  assign err_wide = {in_target[DataW-1], in_target} - {in_measured[DataW-1], in_measured};
  always_comb begin
    if (err_wide[DataW] != err_wide[DataW-1]) begin
      err_sat = err_wide[DataW] ? DataMin : DataMax;
    end else begin
      err_sat = err_wide[DataW-1:0];
    end
  end

  // error difference against the previous item, as sign and magnitude
  assign diff_wide = {err_r[DataW-1], err_r} - {last_error_r[DataW-1], last_error_r};
  assign diff_mag  = diff_wide[DataW] ? (~diff_wide + 1'b1) : diff_wide;
  assign div_start = (state_r == ST_PREP) && (dt_r != '0);

  // derivative: signed quotient saturated to 32 bits, zero for a zero step
  always_comb begin
    if (dt_r == '0) begin
      deriv = '0;
    end else if (!diff_neg_r) begin
      deriv = (|div_quo[QuoW-1:DataW-1]) ? DataMax : div_quo[DataW-1:0];
    end else if ((|div_quo[QuoW-1:DataW]) ||
                 (div_quo[DataW-1] && (|div_quo[DataW-2:0]))) begin
      deriv = DataMin;
    end else begin
      deriv = ~div_quo[DataW-1:0] + 1'b1;
    end
  end

  // integral + floor(error*dt / 2^16), saturated to 48 bits;
  // the product fits 33 bits, so its low bits carry the full value
  assign integ_sum = {integral_r[IntegW-1], integral_r} + mul_prod[IntegW:0];
  always_comb begin
    if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
      integ_sat = integ_sum[IntegW] ? IntegMin : IntegMax;
    end else begin
      integ_sat = integ_sum[IntegW-1:0];
    end
  end

  assign sum_add = sum_r + mul_prod;

  // limits: when the two cross, the upper one wins only if the sum is above it
  assign hi_ext   = {{(ProdW-DataW){out_max_r[DataW-1]}}, out_max_r};
  assign lo_ext   = {{(ProdW-DataW){out_min_r[DataW-1]}}, out_min_r};
  assign over     = (sum_r > hi_ext);
  assign under    = (sum_r < lo_ext);
  assign out_free = !out_valid_r || !out_stall;

  pid_sat_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start_r),
    .mcand  (mcand_r),
    .mplier (mplier_r),
    .prod   (mul_prod),
    .stat   (mul_stat)
  );

  pid_sat_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (diff_mag),
    .divisor (dt_r),
    .quo     (div_quo),
    .stat    (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mul_start_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      integral_r    <= '0;
      last_error_r  <= '0;
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      out_min_r     <= DataMin;
      out_max_r     <= DataMax;
    end else begin
      mul_start_r <= 1'b0;

      // drop the held result once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          RegGainP:  gain_p_r  <= cfg_wdata;
          RegGainI:  gain_i_r  <= cfg_wdata;
          RegGainD:  gain_d_r  <= cfg_wdata;
          RegOutMin: out_min_r <= cfg_wdata;
          RegOutMax: out_max_r <= cfg_wdata;
          default:   ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            err_r   <= err_sat;
            dt_r    <= in_step_time;
            state_r <= ST_PREP;
          end
        end

        ST_PREP: begin
          // divider starts this cycle for a nonzero step; launch error*dt on the multiplier
          diff_neg_r   <= diff_wide[DataW];
          last_error_r <= err_r;
          mcand_r      <= {{(McandW-DtW){1'b0}}, dt_r};
          mplier_r     <= err_r;
          mul_start_r  <= 1'b1;
          state_r      <= ST_MUL_I;
        end

        ST_MUL_I: begin
          if (mul_stat.done) begin
            integral_r  <= integ_sat;
            mcand_r     <= {{(McandW-DataW){err_r[DataW-1]}}, err_r};
            mplier_r    <= gain_p_r;
            mul_start_r <= 1'b1;
            state_r     <= ST_MUL_P;
          end
        end

        ST_MUL_P: begin
          if (mul_stat.done) begin
            sum_r       <= mul_prod;
            mcand_r     <= integral_r;
            mplier_r    <= gain_i_r;
            mul_start_r <= 1'b1;
            state_r     <= ST_MUL_K;
          end
        end

        ST_MUL_K: begin
          if (mul_stat.done) begin
            sum_r   <= sum_add;
            state_r <= ST_DIV_WAIT;
          end
        end

        ST_DIV_WAIT: begin
          // hold until the quotient has settled
          if (!div_stat.busy) begin
            mcand_r     <= {{(McandW-DataW){deriv[DataW-1]}}, deriv};
            mplier_r    <= gain_d_r;
            mul_start_r <= 1'b1;
            state_r     <= ST_MUL_D;
          end
        end

        ST_MUL_D: begin
          if (mul_stat.done) begin
            sum_r   <= sum_add;
            state_r <= ST_CLAMP;
          end
        end

        ST_CLAMP: begin
          // advance only when the output register is free or being emptied
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_clamped_r <= over || under;
            if (over) begin
              out_drive_r <= out_max_r;
            end else if (under) begin
              out_drive_r <= out_min_r;
            end else begin
              out_drive_r <= sum_r[DataW-1:0];
            end
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_clamped = out_clamped_r;

  // multiplier is never restarted mid-product
  a_mul_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start_r |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // no unit activity left over once the item is finished
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!mul_stat.busy && !mul_stat.done && !div_stat.busy))
    else $error("unit still active in idle");

  // divider only runs for a nonzero time step
  a_div_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> (dt_r != '0))
    else $error("divider active with zero time step");

  // derivative product only uses a finished quotient
  a_kd_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_D) |-> !div_stat.busy)
    else $error("derivative multiply overlaps division");

endmodule
